/* hw/rtl/mer_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_pkg - shared definitions for the midpoint ellipse rasterizer
// Defaults, register map and sequencer states.
// ----------------------------------------------------------------------------
package mer_pkg;

    localparam int COORD_BITS_DEF = 11;
    localparam int COLOR_W        = 16;
    localparam int APB_DATA_W     = 32;
    localparam int PADDR_W        = 4;
    localparam int REG_IDX_W      = 2;

    typedef logic [REG_IDX_W-1:0] reg_idx_t;

    localparam reg_idx_t REG_AXIS_X = 2'd0;
    localparam reg_idx_t REG_AXIS_Y = 2'd1;
    localparam reg_idx_t REG_COLOR  = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ_A,
        ST_SQ_B,
        ST_D0,
        ST_D0_FIN,
        ST_T1,
        ST_T2,
        ST_T3,
        ST_R1_A,
        ST_R1_B,
        ST_R1_C,
        ST_SW_A,
        ST_SW_B,
        ST_SW_C,
        ST_SW_D,
        ST_SW_E,
        ST_SW_F,
        ST_R2_A,
        ST_R2_B,
        ST_R2_C,
        ST_EMIT
    } mer_state_t;

endpackage

/* hw/rtl/midpoint_ellipse_rasterizer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer - first-quadrant midpoint ellipse point walker
// One shared multiplier under a small sequencer steps the midpoint decision.
// ----------------------------------------------------------------------------
// Usage:
//   Program axis_x, axis_y and color over the APB port (byte addresses 0, 4
//   and 8) while the block is idle. Each transfer on the s_ channel is one
//   tick: s_restart high starts a new ellipse and yields the point
//   (0, axis_y); s_restart low yields the next point of the quadrant. The
//   point with y = 0 carries m_last; ticks after it (or before any restart)
//   are taken and yield nothing.
//   Each tick is worked through a single multiplier, one product a cycle, so
//   s_ready is high only between ticks. A restart squares both axes and
//   seeds the decision; a region-1 point tests the region, then steps; the
//   point that crosses into region 2 also reseeds the decision; a region-2
//   point steps; an idle tick does no work. Each point ends in the emit step.
//   Results sit in an output register; a new tick is taken while a result
//   still waits, and the sequencer holds in its emit step until m_ready
//   frees the register. Reset (aresetn low, synchronous) clears the
//   registers, the sequencer and the output valid; no ellipse is active.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer #(
    parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mer_pkg::PADDR_W-1:0]         paddr,
    input  logic [mer_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [mer_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    // tick channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_restart,
    // point channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [COORD_BITS-1:0]               m_x_coord,
    output logic [COORD_BITS-1:0]               m_y_coord,
    output logic [mer_pkg::COLOR_W-1:0]         m_point_value,
    output logic                                m_last
);

    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int OP_W   = 2 * COORD_BITS + 2;
    localparam int PROD_W = 2 * OP_W;
    localparam int DEC_W  = 4 * COORD_BITS + 6;

    // configuration registers
    logic [COORD_BITS-1:0]       axis_x_reg;
    logic [COORD_BITS-1:0]       axis_y_reg;
    logic [mer_pkg::COLOR_W-1:0] color_reg;
    mer_pkg::reg_idx_t           reg_idx;
    logic                        cfg_wr;

    // walker state
    mer_pkg::mer_state_t state_reg, state_next;
    logic [COORD_BITS-1:0] x_reg, x_next;
    logic [COORD_BITS-1:0] y_reg, y_next;
    logic [DEC_W-1:0]      dec_reg, dec_next;
    logic [DEC_W-1:0]      hold_reg, hold_next;
    logic [SQ_W-1:0]       a2_reg, a2_next;
    logic [SQ_W-1:0]       b2_reg, b2_next;
    logic                  r2_reg, r2_next;
    logic                  active_reg, active_next;

    // shared multiplier
    logic [OP_W-1:0]       mul_a, mul_b;
    logic [PROD_W-1:0]     prod_reg, prod_next;

    // output register
    logic                        m_valid_reg, m_valid_next;
    logic [COORD_BITS-1:0]       m_x_reg, m_x_next;
    logic [COORD_BITS-1:0]       m_y_reg, m_y_next;
    logic [mer_pkg::COLOR_W-1:0] m_val_reg, m_val_next;
    logic                        m_last_reg, m_last_next;

    logic                  in_xfer;
    logic                  out_load;
    logic                  dec_neg;
    logic [DEC_W-1:0]      prod_ext;
    logic [DEC_W-1:0]      a2_ext;
    logic [DEC_W-1:0]      b2_ext;

    // ------------------------------------------------------------------
    // APB register file: always ready, write in the access phase
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[mer_pkg::PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_x_reg <= '0;
            axis_y_reg <= '0;
            color_reg  <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                mer_pkg::REG_AXIS_X: axis_x_reg <= pwdata[COORD_BITS-1:0];
                mer_pkg::REG_AXIS_Y: axis_y_reg <= pwdata[COORD_BITS-1:0];
                mer_pkg::REG_COLOR:  color_reg  <= pwdata[mer_pkg::COLOR_W-1:0];
                default: ;  // unmapped address: drop the write
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            mer_pkg::REG_AXIS_X: prdata = mer_pkg::APB_DATA_W'(axis_x_reg);
            mer_pkg::REG_AXIS_Y: prdata = mer_pkg::APB_DATA_W'(axis_y_reg);
            mer_pkg::REG_COLOR:  prdata = mer_pkg::APB_DATA_W'(color_reg);
            default:             prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake and shared signals
    // ------------------------------------------------------------------
    assign s_ready  = (state_reg == mer_pkg::ST_IDLE);
    assign in_xfer  = s_valid && s_ready;
    assign out_load = !m_valid_reg || m_ready;

    // decision kept four times scaled, two's complement; sign is the MSB
    assign dec_neg  = dec_reg[DEC_W-1];
    assign prod_ext = DEC_W'(prod_reg);
    assign a2_ext   = DEC_W'(a2_reg);
    assign b2_ext   = DEC_W'(b2_reg);

    // one product a cycle, registered before any use
    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    // ------------------------------------------------------------------
    // Sequencer: operand selection, state update and point capture
    // ------------------------------------------------------------------
    always_comb begin
        state_next   = state_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        dec_next     = dec_reg;
        hold_next    = hold_reg;
        a2_next      = a2_reg;
        b2_next      = b2_reg;
        r2_next      = r2_reg;
        active_next  = active_reg;
        mul_a        = '0;
        mul_b        = '0;
        m_valid_next = m_valid_reg && !m_ready;
        m_x_next     = m_x_reg;
        m_y_next     = m_y_reg;
        m_val_next   = m_val_reg;
        m_last_next  = m_last_reg;

        unique case (state_reg)
            mer_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    priority if (s_restart) begin
                        state_next = mer_pkg::ST_SQ_A;
                    end else if (active_reg && r2_reg) begin
                        state_next = mer_pkg::ST_R2_A;
                    end else if (active_reg) begin
                        state_next = mer_pkg::ST_T1;
                    end else begin
                        state_next = mer_pkg::ST_IDLE;  // no ellipse: drop the tick
                    end
                end
            end
            // restart: latch squares, seed the region-1 decision
            mer_pkg::ST_SQ_A: begin
                mul_a      = OP_W'(axis_x_reg);
                mul_b      = OP_W'(axis_x_reg);
                state_next = mer_pkg::ST_SQ_B;
            end
            mer_pkg::ST_SQ_B: begin
                a2_next    = prod_reg[SQ_W-1:0];
                mul_a      = OP_W'(axis_y_reg);
                mul_b      = OP_W'(axis_y_reg);
                state_next = mer_pkg::ST_D0;
            end
            mer_pkg::ST_D0: begin
                b2_next    = prod_reg[SQ_W-1:0];
                mul_a      = OP_W'(a2_reg);
                mul_b      = OP_W'(axis_y_reg);
                state_next = mer_pkg::ST_D0_FIN;
            end
            mer_pkg::ST_D0_FIN: begin
                dec_next    = (b2_ext << 2) - (prod_ext << 2) + a2_ext;
                x_next      = '0;
                y_next      = axis_y_reg;
                r2_next     = 1'b0;
                active_next = 1'b1;
                state_next  = mer_pkg::ST_EMIT;
            end
            // region-1 test: a^2 (2y-1) > 2 b^2 (x+1)
            mer_pkg::ST_T1: begin
                mul_a      = OP_W'(a2_reg);
                mul_b      = OP_W'({y_reg, 1'b0}) - OP_W'(1);
                state_next = mer_pkg::ST_T2;
            end
            mer_pkg::ST_T2: begin
                hold_next  = prod_ext;
                mul_a      = OP_W'(b2_reg);
                mul_b      = OP_W'(x_reg) + OP_W'(1);
                state_next = mer_pkg::ST_T3;
            end
            mer_pkg::ST_T3: begin
                state_next = (hold_reg > (prod_ext << 1)) ? mer_pkg::ST_R1_A
                                                           : mer_pkg::ST_SW_A;
            end
            // region-1 step
            mer_pkg::ST_R1_A: begin
                mul_a      = OP_W'(b2_reg);
                mul_b      = OP_W'({x_reg, 1'b0}) + OP_W'(3);
                state_next = mer_pkg::ST_R1_B;
            end
            mer_pkg::ST_R1_B: begin
                if (dec_neg) begin
                    dec_next   = dec_reg + (prod_ext << 2);
                    x_next     = x_reg + COORD_BITS'(1);
                    state_next = mer_pkg::ST_EMIT;
                end else begin
                    hold_next  = prod_ext << 2;
                    mul_a      = OP_W'(a2_reg);
                    mul_b      = OP_W'(y_reg);
                    state_next = mer_pkg::ST_R1_C;
                end
            end
            mer_pkg::ST_R1_C: begin
                dec_next   = dec_reg + hold_reg + (a2_ext << 3) - (prod_ext << 3);
                x_next     = x_reg + COORD_BITS'(1);
                y_next     = y_reg - COORD_BITS'(1);
                state_next = mer_pkg::ST_EMIT;
            end
            // region change: b^2 (2x+1)^2 + 4a^2 (y-1)^2 - 4a^2 b^2
            mer_pkg::ST_SW_A: begin
                mul_a      = OP_W'({x_reg, 1'b1});
                mul_b      = OP_W'({x_reg, 1'b1});
                state_next = mer_pkg::ST_SW_B;
            end
            mer_pkg::ST_SW_B: begin
                mul_a      = OP_W'(b2_reg);
                mul_b      = prod_reg[OP_W-1:0];
                state_next = mer_pkg::ST_SW_C;
            end
            mer_pkg::ST_SW_C: begin
                hold_next  = prod_ext;
                mul_a      = OP_W'(y_reg) - OP_W'(1);
                mul_b      = OP_W'(y_reg) - OP_W'(1);
                state_next = mer_pkg::ST_SW_D;
            end
            mer_pkg::ST_SW_D: begin
                mul_a      = OP_W'(a2_reg);
                mul_b      = prod_reg[OP_W-1:0];
                state_next = mer_pkg::ST_SW_E;
            end
            mer_pkg::ST_SW_E: begin
                hold_next  = hold_reg + (prod_ext << 2);
                mul_a      = OP_W'(a2_reg);
                mul_b      = OP_W'(b2_reg);
                state_next = mer_pkg::ST_SW_F;
            end
            mer_pkg::ST_SW_F: begin
                dec_next   = hold_reg - (prod_ext << 2);
                r2_next    = 1'b1;
                state_next = mer_pkg::ST_R2_A;
            end
            // region-2 step
            mer_pkg::ST_R2_A: begin
                mul_a      = OP_W'(a2_reg);
                mul_b      = OP_W'(y_reg);
                state_next = mer_pkg::ST_R2_B;
            end
            mer_pkg::ST_R2_B: begin
                if (dec_neg) begin
                    hold_next  = (a2_ext << 3) + (a2_ext << 2) - (prod_ext << 3);
                    mul_a      = OP_W'(b2_reg);
                    mul_b      = OP_W'(x_reg) + OP_W'(1);
                    state_next = mer_pkg::ST_R2_C;
                end else begin
                    dec_next   = dec_reg + (a2_ext << 3) + (a2_ext << 2)
                                 - (prod_ext << 3);
                    y_next     = y_reg - COORD_BITS'(1);
                    state_next = mer_pkg::ST_EMIT;
                end
            end
            mer_pkg::ST_R2_C: begin
                dec_next   = dec_reg + hold_reg + (prod_ext << 3);
                x_next     = x_reg + COORD_BITS'(1);
                y_next     = y_reg - COORD_BITS'(1);
                state_next = mer_pkg::ST_EMIT;
            end
            // hold here until the output register is free
            mer_pkg::ST_EMIT: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    m_x_next     = x_reg;
                    m_y_next     = y_reg;
                    m_val_next   = color_reg;
                    m_last_next  = (y_reg == '0);
                    if (y_reg == '0) begin
                        active_next = 1'b0;
                    end
                    state_next   = mer_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mer_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mer_pkg::ST_IDLE;
            active_reg  <= 1'b0;
            r2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            x_reg       <= '0;
            y_reg       <= '0;
            dec_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            active_reg  <= active_next;
            r2_reg      <= r2_next;
            m_valid_reg <= m_valid_next;
            x_reg       <= x_next;
            y_reg       <= y_next;
            dec_reg     <= dec_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg   <= prod_next;
        hold_reg   <= hold_next;
        a2_reg     <= a2_next;
        b2_reg     <= b2_next;
        m_x_reg    <= m_x_next;
        m_y_reg    <= m_y_next;
        m_val_reg  <= m_val_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_x_coord     = m_x_reg;
    assign m_y_coord     = m_y_reg;
    assign m_point_value = m_val_reg;
    assign m_last        = m_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_restart_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer && s_restart |=> ##4 (state_reg == mer_pkg::ST_EMIT))
        else $error("restart did not reach the emit step in five cycles");

    a_idle_tick_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer && !s_restart && !active_reg |=> (state_reg == mer_pkg::ST_IDLE))
        else $error("tick without an active ellipse started work");

    a_emit_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mer_pkg::ST_EMIT) && m_valid_reg && !m_ready
        |=> (state_reg == mer_pkg::ST_EMIT))
        else $error("emit step left while the output register was occupied");

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mer_pkg::ST_EMIT) && out_load && (y_reg == '0)
        |=> !active_reg && m_valid_reg && m_last_reg)
        else $error("last point did not close the ellipse");

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - midpoint ellipse rasterizer
// Programs the semi-axes and colour over APB, walks ellipses tick by tick and
// scores every emitted point against an independent midpoint-ellipse tracer or
// a typed point, random idling on both channels, one long output back-pressure.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CB       = mer_pkg::COORD_BITS_DEF;
    localparam int LIMIT    = 400000;   // cycle ceiling for the whole run
    localparam int SETTLE   = 20;       // pad past the longest tick
    localparam int HOLD_LEN = 300;      // long receiver hold-off
    localparam int N_DIR    = 35;

    typedef struct packed {
        logic [CB-1:0]               x;
        logic [CB-1:0]               y;
        logic [mer_pkg::COLOR_W-1:0] val;
        logic                        last;
    } point_t;

    typedef enum logic [0:0] {ROW_CFG, ROW_TICK} row_kind_t;
    typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_POINT} exp_kind_t;

    typedef struct packed {
        row_kind_t                      kind;
        mer_pkg::reg_idx_t              idx;
        logic [mer_pkg::APB_DATA_W-1:0] wdata;
        logic                           restart;
        exp_kind_t                      chk;
        point_t                         pt;
    } row_t;

    // Directed rows: register writes and ticks. Typed points are the obvious
    // ones (first point, zero axes, end of walk); the rest go to the tracer.
    localparam row_t DIR_ROWS [N_DIR] = '{
        // advance before any restart: swallowed
        '{ROW_TICK, mer_pkg::REG_AXIS_X, 32'h0,         1'b0, EXP_NONE,  '0},
        // zero axes, upper bits of the write set and ignored
        '{ROW_CFG,  mer_pkg::REG_AXIS_X, 32'hFFFF_F800, 1'b0, EXP_MODEL, '0},
        '{ROW_CFG,  mer_pkg::REG_AXIS_Y, 32'h0,         1'b0, EXP_MODEL, '0},
        '{ROW_CFG,  mer_pkg::REG_COLOR,  32'h0000_FFFF, 1'b0, EXP_MODEL, '0},
        // zero y axis: first point is already last, then nothing
        '{ROW_TICK, mer_pkg::REG_AXIS_X, 32'h0,         1'b1, EXP_POINT,
          '{11'd0, 11'd0, 16'hFFFF, 1'b1}},
        '{ROW_TICK, mer_pkg::REG_AXIS_X, 32'h0,         1'b0, EXP_NONE,  '0},
        // zero x axis: straight walk down x = 0
        '{ROW_CFG,  mer_pkg::REG_AXIS_Y, 32'h3,         1'b0, EXP_MODEL, '0},
        '{ROW_CFG,  mer_pkg::REG_COLOR,  32'h0,         1'b0, EXP_MODEL, '0},
        '{ROW_TICK, mer_pkg::REG_AXIS_X, 32'h0,         1'b1, EXP_POINT,
          '{11'd0, 11'd3, 16'h0, 1'b0}},
        '{ROW_TICK, mer_pkg::REG_AXIS_X, 32'h0,         1'b0, EXP_POINT,
          '{11'd0, 11'd2, 16'h0, 1'b0}},
        '{ROW_TICK, mer_pkg::REG_AXIS_X, 32'h0,         1'b0, EXP_POINT,
          '{11'd0, 11'd1, 16'h0, 1'b0}},
        '{ROW_TICK, mer_pkg::REG_AXIS_X, 32'h0,         1'b0, EXP_POINT,
          '{11'd0, 11'd0, 16'h0, 1'b1}},
        // largest axes
        '{ROW_CFG,  mer_pkg::REG_AXIS_X, 32'h0000_07FF, 1'b0, EXP_MODEL, '0},
        '{ROW_CFG,  mer_pkg::REG_AXIS_Y, 32'hFFFF_FFFF, 1'b0, EXP_MODEL, '0},
        '{ROW_CFG,  mer_pkg::REG_COLOR,  32'hABCD_A5A5, 1'b0, EXP_MODEL, '0},
        '{ROW_TICK, mer_pkg::REG_AXIS_X, 32'h0,         1'b1, EXP_POINT,
          '{11'd0, 11'd2047, 16'hA5A5, 1'b0}},
        '{ROW_TICK, mer_pkg::REG_AXIS_X, 32'h0,         1'b0, EXP_MODEL, '0},
        '{ROW_TICK, mer_pkg::REG_AXIS_X, 32'h0,         1'b0, EXP_MODEL, '0},
        // restart mid-walk, then rewrite an axis: the walk keeps its latch
        '{ROW_TICK, mer_pkg::REG_AXIS_X, 32'h0,         1'b1, EXP_POINT,
          '{11'd0, 11'd2047, 16'hA5A5, 1'b0}},
        '{ROW_CFG,  mer_pkg::REG_AXIS_Y, 32'h1,         1'b0, EXP_MODEL, '0},
        '{ROW_TICK, mer_pkg::REG_AXIS_X, 32'h0,         1'b0, EXP_MODEL, '0},
        // flat ellipse: region 1 runs all the way to y = 0
        '{ROW_CFG,  mer_pkg::REG_AXIS_X, 32'h5,         1'b0, EXP_MODEL, '0},
        '{ROW_TICK, mer_pkg::REG_AXIS_X, 32'h0,         1'b1, EXP_POINT,
          '{11'd0, 11'd1, 16'hA5A5, 1'b0}},
        '{ROW_TICK, mer_pkg::REG_AXIS_X, 32'h0,         1'b0, EXP_MODEL, '0},
        '{ROW_TICK, mer_pkg::REG_AXIS_X, 32'h0,         1'b0, EXP_MODEL, '0},
        '{ROW_TICK, mer_pkg::REG_AXIS_X, 32'h0,         1'b0, EXP_MODEL, '0},
        '{ROW_TICK, mer_pkg::REG_AXIS_X, 32'h0,         1'b0, EXP_MODEL, '0},
        '{ROW_TICK, mer_pkg::REG_AXIS_X, 32'h0,         1'b0, EXP_MODEL, '0},
        // small circle: crosses into region 2 on the second advance
        '{ROW_CFG,  mer_pkg::REG_AXIS_X, 32'h2,         1'b0, EXP_MODEL, '0},
        '{ROW_CFG,  mer_pkg::REG_AXIS_Y, 32'h2,         1'b0, EXP_MODEL, '0},
        '{ROW_CFG,  mer_pkg::REG_COLOR,  32'h0,         1'b0, EXP_MODEL, '0},
        '{ROW_TICK, mer_pkg::REG_AXIS_X, 32'h0,         1'b1, EXP_POINT,
          '{11'd0, 11'd2, 16'h0, 1'b0}},
        '{ROW_TICK, mer_pkg::REG_AXIS_X, 32'h0,         1'b0, EXP_MODEL, '0},
        '{ROW_TICK, mer_pkg::REG_AXIS_X, 32'h0,         1'b0, EXP_MODEL, '0},
        '{ROW_TICK, mer_pkg::REG_AXIS_X, 32'h0,         1'b0, EXP_MODEL, '0}
    };

    // ------------------------------------------------------------------
    // Signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic                           aclk    = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           psel    = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite  = 1'b0;
    logic [mer_pkg::PADDR_W-1:0]    paddr   = '0;
    logic [mer_pkg::APB_DATA_W-1:0] pwdata  = '0;
    logic [mer_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;
    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    logic                           s_restart = 1'b0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    logic [CB-1:0]                  m_x_coord;
    logic [CB-1:0]                  m_y_coord;
    logic [mer_pkg::COLOR_W-1:0]    m_point_value;
    logic                           m_last;

    // Register copies and the tracer's walk state
    logic [CB-1:0]               shadow_axis_x = '0;
    logic [CB-1:0]               shadow_axis_y = '0;
    logic [mer_pkg::COLOR_W-1:0] shadow_color  = '0;
    logic [CB-1:0]      walk_x   = '0;
    logic [CB-1:0]      walk_y   = '0;
    logic [63:0]        walk_dec = '0;     // decision times four, modulo 2^64
    logic [63:0]        walk_a2  = '0;
    logic [63:0]        walk_b2  = '0;
    logic               walk_r2  = 1'b0;
    logic               walk_on  = 1'b0;

    point_t pending_points[$];
    int     errors      = 0;
    int     points_sent = 0;
    int     cycle_count = 0;
    int     src_idle    = 0;    // percent of cycles the sender idles
    int     rcv_idle    = 0;    // percent of cycles the receiver stalls
    bit     hold_req    = 1'b0;
    int     hold_left   = 0;

    midpoint_ellipse_rasterizer #(.COORD_BITS(CB)) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_restart     (s_restart),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_x_coord     (m_x_coord),
        .m_y_coord     (m_y_coord),
        .m_point_value (m_point_value),
        .m_last        (m_last)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Midpoint ellipse tracer: one call per accepted tick, returns 1 with
    // the point when the tick yields one
    // ------------------------------------------------------------------
    function automatic bit trace_point(input logic restart, output point_t pt);
        logic [63:0] a2, b2, x, y, t;
        pt = '0;
        // idle advance: nothing moves
        if (!restart && !walk_on) return 1'b0;
        if (restart) begin
            // latch the squares and seed region 1 at (0, b)
            walk_a2  = 64'(shadow_axis_x) * 64'(shadow_axis_x);
            walk_b2  = 64'(shadow_axis_y) * 64'(shadow_axis_y);
            walk_x   = '0;
            walk_y   = shadow_axis_y;
            walk_dec = 64'd4 * walk_b2 - 64'd4 * walk_a2 * 64'(shadow_axis_y) + walk_a2;
            walk_r2  = 1'b0;
            walk_on  = 1'b1;
        end else begin
            a2 = walk_a2;
            b2 = walk_b2;
            x  = 64'(walk_x);
            y  = 64'(walk_y);
            if (!walk_r2 && a2 * (64'd2 * y - 64'd1) > 64'd2 * b2 * (x + 64'd1)) begin
                // region 1: step x, step y down on a non-negative decision
                t = 64'd4 * b2 * (64'd2 * x + 64'd3);
                if (walk_dec[63]) begin
                    walk_dec += t;
                end else begin
                    walk_dec += t + 64'd8 * a2 - 64'd8 * a2 * y;
                    y -= 64'd1;
                end
                x += 64'd1;
            end else begin
                if (!walk_r2) begin
                    // crossing: reseed the decision for region 2 in this tick
                    t        = 64'd2 * x + 64'd1;
                    walk_dec = b2 * t * t + 64'd4 * a2 * (y - 64'd1) * (y - 64'd1)
                               - 64'd4 * a2 * b2;
                    walk_r2  = 1'b1;
                end
                t = 64'd12 * a2 - 64'd8 * a2 * y;
                if (walk_dec[63]) begin
                    walk_dec += 64'd4 * b2 * (64'd2 * x + 64'd2) + t;
                    x += 64'd1;
                end else begin
                    walk_dec += t;
                end
                y -= 64'd1;
            end
            walk_x = x[CB-1:0];
            walk_y = y[CB-1:0];
        end
        pt.x    = walk_x;
        pt.y    = walk_y;
        pt.val  = shadow_color;
        pt.last = (walk_y == '0);
        if (walk_y == '0) walk_on = 1'b0;
        return 1'b1;
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Offer one tick, hold it until the transfer, then book its point
    task automatic send_tick(input logic restart, input exp_kind_t chk, input point_t typed);
        point_t pt;
        bit     has_pt;
        while ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_restart <= restart;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        has_pt = trace_point(restart, pt);
        case (chk)
            EXP_MODEL: if (has_pt) pending_points.push_back(pt);
            EXP_POINT: pending_points.push_back(typed);
            default: ;
        endcase
        if (has_pt) points_sent++;
    endtask

    // Drop valid, wait for every booked point, then let a swallowed tick finish
    task automatic settle_block();
        s_valid <= 1'b0;
        while (pending_points.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // APB write followed by a read-back of the same register
    task automatic cfg_write(input mer_pkg::reg_idx_t idx,
                             input logic [mer_pkg::APB_DATA_W-1:0] data);
        logic [mer_pkg::APB_DATA_W-1:0] kept;
        case (idx)
            mer_pkg::REG_AXIS_X: kept = mer_pkg::APB_DATA_W'(data[CB-1:0]);
            mer_pkg::REG_AXIS_Y: kept = mer_pkg::APB_DATA_W'(data[CB-1:0]);
            default:    kept = mer_pkg::APB_DATA_W'(data[mer_pkg::COLOR_W-1:0]);
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            mer_pkg::REG_AXIS_X: shadow_axis_x = kept[CB-1:0];
            mer_pkg::REG_AXIS_Y: shadow_axis_y = kept[CB-1:0];
            default:             shadow_color  = kept[mer_pkg::COLOR_W-1:0];
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        check_field("prdata", kept, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // One random phase: settings drawn mostly small so walks finish, a few
    // wide ones walked only part of the way; most ellipses are complete walks
    task automatic run_phase(input int src_pct, input int rcv_pct, input int budget,
                             input bit squeeze);
        int            goal;
        int            cap;
        int            kind;
        int            steps;
        bit            hold_pending;
        logic [CB-1:0] ax, ay;
        src_idle     = src_pct;
        rcv_idle     = rcv_pct;
        hold_pending = squeeze;
        goal         = points_sent + budget;
        while (points_sent < goal) begin
            settle_block();
            kind = $urandom_range(99);
            if (kind < 80) begin
                ax = CB'($urandom_range(20));
                ay = CB'($urandom_range(20));
            end else if (kind < 92) begin
                ax = CB'($urandom_range(150));
                ay = CB'($urandom_range(150));
            end else begin
                ax = $urandom_range(1) ? '1 : '0;
                ay = $urandom_range(1) ? '1 : '0;
            end
            cap = (ax > 150 || ay > 150) ? 40 : 1000;
            cfg_write(mer_pkg::REG_AXIS_X, ($urandom & ~32'h7FF) | 32'(ax));
            cfg_write(mer_pkg::REG_AXIS_Y, ($urandom & ~32'h7FF) | 32'(ay));
            cfg_write(mer_pkg::REG_COLOR, $urandom);
            if (hold_pending) begin
                // starve the output while ticks keep coming
                hold_req     = 1'b1;
                hold_pending = 1'b0;
            end
            repeat ($urandom_range(1, 4)) begin
                kind = $urandom_range(99);
                if (kind < 80) begin
                    send_tick(1'b1, EXP_MODEL, '0);
                    steps = 0;
                    while (walk_on && steps < cap) begin
                        send_tick(1'b0, EXP_MODEL, '0);
                        steps++;
                    end
                end else if (kind < 90) begin
                    repeat ($urandom_range(1, 3)) send_tick(1'b0, EXP_MODEL, '0);
                end else begin
                    // broken walk, abandoned by the next restart
                    send_tick(1'b1, EXP_MODEL, '0);
                    repeat ($urandom_range(0, 5)) send_tick(1'b0, EXP_MODEL, '0);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_LEN;
            hold_req  = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    // ------------------------------------------------------------------
    // Scoreboard: each point transfer against the oldest booked point
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : score
        point_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_points.size() == 0) begin
                errors++;
                $display("%0t: point mismatch: expected none, got x=%0d y=%0d value=%h last=%b",
                         $time, m_x_coord, m_y_coord, m_point_value, m_last);
            end else begin
                want = pending_points.pop_front();
                check_field("x_coord", 32'(want.x), 32'(m_x_coord));
                check_field("y_coord", 32'(want.y), 32'(m_y_coord));
                check_field("point_value", 32'(want.val), 32'(m_point_value));
                check_field("last", 32'(want.last), 32'(m_last));
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: reset, directed rows, then three random phases
    // ------------------------------------------------------------------
    initial begin : stimulus
        row_t row;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        src_idle = 22;
        rcv_idle = 85;
        for (int i = 0; i < N_DIR; i++) begin
            row = DIR_ROWS[i];
            if (row.kind == ROW_CFG) begin
                settle_block();
                cfg_write(row.idx, row.wdata);
            end else begin
                send_tick(row.restart, row.chk, row.pt);
            end
        end
        run_phase(22, 85, 200, 1'b0);
        run_phase(85, 22, 200, 1'b0);
        run_phase(0, 0, 200, 1'b1);
        // drain and let the last tick settle before scoring
        settle_block();
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
